[rtl/lcdrc_pkg.sv]
// Shared types, constants and helpers for the character LCD nibble driver
// with row cache. No dependencies.
package lcdrc_pkg;

  localparam int COLUMNS  = 16;
  localparam int ROWS     = 2;
  localparam int COL_W    = $clog2(COLUMNS);
  localparam int CNT_W    = $clog2(COLUMNS + 1);
  localparam int ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int SHOWN_N  = ROWS * COLUMNS;
  localparam int SHOWN_AW = $clog2(SHOWN_N);
  localparam int INIT_LEN = 6;

  localparam logic [7:0] CURSOR_ROW0 = 8'h80;
  localparam logic [7:0] CURSOR_ROW1 = 8'hC0;
  localparam logic [7:0] BIT_BL      = 8'b0000_1000;
  localparam logic [7:0] BIT_RS      = 8'b0000_0001;
  localparam logic [7:0] BIT_EN      = 8'b0000_0100;
  localparam logic [7:0] CMD_CLEAR   = 8'h01;
  localparam logic [7:0] CHAR_BLANK  = 8'h20;

  typedef enum logic [2:0] {
    MODE_ROW    = 3'd0,
    MODE_PRINT  = 3'd1,
    MODE_CLEAR  = 3'd2,
    MODE_BL_ON  = 3'd3,
    MODE_BL_OFF = 3'd4,
    MODE_INIT   = 3'd5,
    MODE_CURSOR = 3'd6
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUT,
    ST_HI,
    ST_LO,
    ST_FETCH,
    ST_LOAD,
    ST_CMP_RD,
    ST_CMP_CHK
  } state_t;

  typedef enum logic [1:0] {
    JOB_ONE,
    JOB_ROW,
    JOB_INIT
  } job_t;

  typedef struct packed {
    logic [7:0] latch_byte;
    logic       strobe_res;
    logic       last;
  } res_t;

  function automatic logic [7:0] init_byte(input logic [2:0] i);
    case (i)
      3'd0:    init_byte = 8'b0011_0011;
      3'd1:    init_byte = 8'b0011_0010;
      3'd2:    init_byte = 8'b0010_1000;
      3'd3:    init_byte = 8'b0000_1100;
      3'd4:    init_byte = 8'b0000_0110;
      default: init_byte = CMD_CLEAR;
    endcase
  endfunction

  function automatic logic [7:0] cursor_base(input logic [ROW_W-1:0] r);
    cursor_base = (r == ROW_W'(1)) ? CURSOR_ROW1 : CURSOR_ROW0;
  endfunction

  function automatic logic [SHOWN_AW-1:0] shown_addr(input logic [ROW_W-1:0] r,
                                                     input logic [COL_W-1:0] c);
    shown_addr = SHOWN_AW'(r) * SHOWN_AW'(COLUMNS) + SHOWN_AW'(c);
  endfunction

  // Latch byte for one nibble: nibble high, kept backlight, enable low, RS.
  function automatic logic [7:0] nib_byte(input logic [3:0] nib, input logic [7:0] ls,
                                          input logic rs);
    nib_byte = {nib, ls[3], 3'b000} | (rs ? BIT_RS : 8'h00);
    nib_byte = nib_byte & ~BIT_EN;
  endfunction

endpackage

[rtl/lcdrc_in_if.sv]
// Input channel of the LCD driver: valid/ready with mode, character, row, column.
// No dependencies.
interface lcdrc_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic [7:0] text_char;
  logic       row;
  logic [5:0] column;

  modport source(output valid, output mode, output text_char, output row,
                 output column, input ready);
  modport sink(input valid, input mode, input text_char, input row,
               input column, output ready);
endinterface

[rtl/lcdrc_out_if.sv]
// Result channel of the LCD driver: valid/ready with latch byte, strobe, last.
// No dependencies.
interface lcdrc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] latch_byte;
  logic       strobe_res;
  logic       last;

  modport source(output valid, output latch_byte, output strobe_res,
                 output last, input ready);
  modport sink(input valid, input latch_byte, input strobe_res,
               input last, output ready);
endinterface

[rtl/lcdrc_out_stage.sv]
// Output register of the LCD driver; holds one result until its transfer.
// Depends on lcdrc_pkg and lcdrc_out_if.
module lcdrc_out_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lcdrc_pkg::res_t push_res,
  output logic           can_push,
  lcdrc_out_if.source    result
);
  import lcdrc_pkg::*;

  logic valid;
  res_t data;

  assign can_push = !valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (push) begin
      valid <= 1'b1;
    end else if (result.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data <= push_res;
    end
  end

  assign result.valid      = valid;
  assign result.latch_byte = data.latch_byte;
  assign result.strobe_res = data.strobe_res;
  assign result.last       = data.last;
endmodule

[rtl/char_lcd_nibble_driver_row_cache_unit.sv]
// Top level of the character LCD nibble driver with row cache.
// Depends on lcdrc_pkg, lcdrc_in_if, lcdrc_out_if and lcdrc_out_stage.
//
// Usage:
//   item   - valid/ready input channel; one transfer per command or character.
//   result - valid/ready output channel; one transfer per expander latch byte,
//            with last set on the final byte caused by an item.
// Row text characters are taken one per cycle while the sequencer is idle and
// staged in a 16-entry memory. A zero character ends the row: if the row
// cache is valid, the staged text is compared with the cached row column by
// column (memory read, then compare). A changed or invalid row is sent as a
// cursor command plus, per column, a read, a load and two nibbles.
// Item ready is high only while the sequencer is idle; the output register
// lets the next item in while the final result still waits.
// A receiver stall holds the sequencer on the pending latch byte; nothing is lost.
// Reset (synchronous, rst high) clears the latch byte, the row valid bits,
// the staging count and the output valid flag; the memories are not cleared.
module char_lcd_nibble_driver_row_cache_unit (
  input  logic       clk,
  input  logic       rst,
  lcdrc_in_if.sink    item,
  lcdrc_out_if.source result
);
  import lcdrc_pkg::*;

  state_t              state, state_next;
  job_t                job, job_next;
  mode_t               op, op_next;
  logic [7:0]          cur_byte, cur_byte_next;
  logic                cur_rs, cur_rs_next;
  logic [CNT_W-1:0]    idx, idx_next;
  logic [CNT_W-1:0]    cnt_n, cnt_n_next;
  logic [CNT_W-1:0]    stg_count, stg_count_next;
  logic [ROW_W-1:0]    r_sel, r_sel_next;
  logic [7:0]          latch_state, latch_next;
  logic [ROWS-1:0]     row_valid, row_valid_next;
  logic [2:0]          init_idx, init_idx_next;

  logic [7:0]          stg_mem [COLUMNS];
  logic [7:0]          stg_q;
  logic                stg_we;
  logic [COL_W-1:0]    stg_waddr, stg_raddr;
  logic [7:0]          shown_mem [SHOWN_N];
  logic [7:0]          shown_q;
  logic                shown_we;
  logic [SHOWN_AW-1:0] shown_waddr, shown_raddr;
  logic [7:0]          padded;

  logic                push, can_push;
  res_t                push_res;
  mode_t               in_mode;
  logic [ROW_W-1:0]    in_row;

  assign in_mode = mode_t'(item.mode);
  assign in_row  = (32'(item.row) < ROWS) ? ROW_W'(item.row) : ROW_W'(ROWS - 1);
  assign padded  = (idx < cnt_n) ? stg_q : CHAR_BLANK;
  assign item.ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (stg_we) begin
      stg_mem[stg_waddr] <= item.text_char;
    end
    stg_q <= stg_mem[stg_raddr];
  end

  always_ff @(posedge clk) begin
    if (shown_we) begin
      shown_mem[shown_waddr] <= padded;
    end
    shown_q <= shown_mem[shown_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      latch_state <= '0;
      row_valid   <= '0;
      stg_count   <= '0;
    end else begin
      state       <= state_next;
      latch_state <= latch_next;
      row_valid   <= row_valid_next;
      stg_count   <= stg_count_next;
    end
  end

  always_ff @(posedge clk) begin
    job      <= job_next;
    op       <= op_next;
    cur_byte <= cur_byte_next;
    cur_rs   <= cur_rs_next;
    idx      <= idx_next;
    cnt_n    <= cnt_n_next;
    r_sel    <= r_sel_next;
    init_idx <= init_idx_next;
  end

  always_comb begin
    state_next     = state;
    job_next       = job;
    op_next        = op;
    cur_byte_next  = cur_byte;
    cur_rs_next    = cur_rs;
    idx_next       = idx;
    cnt_n_next     = cnt_n;
    stg_count_next = stg_count;
    r_sel_next     = r_sel;
    latch_next     = latch_state;
    row_valid_next = row_valid;
    init_idx_next  = init_idx;
    stg_we         = 1'b0;
    stg_waddr      = stg_count[COL_W-1:0];
    stg_raddr      = idx[COL_W-1:0];
    shown_we       = 1'b0;
    shown_waddr    = shown_addr(r_sel, idx[COL_W-1:0]);
    shown_raddr    = shown_addr(r_sel, idx[COL_W-1:0]);
    push           = 1'b0;
    push_res       = '0;

    case (state)
      ST_IDLE: begin
        if (item.valid) begin
          case (in_mode)
            MODE_ROW: begin
              if (item.text_char != 8'h00) begin
                if (stg_count < CNT_W'(COLUMNS)) begin
                  stg_we         = 1'b1;
                  stg_count_next = stg_count + CNT_W'(1);
                end
              end else begin
                cnt_n_next     = stg_count;
                stg_count_next = '0;
                r_sel_next     = in_row;
                idx_next       = '0;
                if (row_valid[in_row]) begin
                  state_next = ST_CMP_RD;
                end else begin
                  cur_byte_next = cursor_base(in_row);
                  cur_rs_next   = 1'b0;
                  job_next      = JOB_ROW;
                  state_next    = ST_HI;
                end
              end
            end
            MODE_PRINT: begin
              row_valid_next = '0;
              if (item.text_char != 8'h00) begin
                cur_byte_next = item.text_char;
                cur_rs_next   = 1'b1;
                job_next      = JOB_ONE;
                state_next    = ST_HI;
              end
            end
            MODE_CLEAR: begin
              row_valid_next = '0;
              cur_byte_next  = CMD_CLEAR;
              cur_rs_next    = 1'b0;
              job_next       = JOB_ONE;
              state_next     = ST_HI;
            end
            MODE_BL_ON, MODE_BL_OFF: begin
              op_next    = in_mode;
              state_next = ST_PUT;
            end
            MODE_INIT: begin
              row_valid_next = '0;
              op_next        = in_mode;
              state_next     = ST_PUT;
            end
            MODE_CURSOR: begin
              cur_byte_next = {2'b00, item.column} | cursor_base(ROW_W'(item.row));
              cur_rs_next   = 1'b0;
              job_next      = JOB_ONE;
              state_next    = ST_HI;
            end
            default: begin
            end
          endcase
        end
      end
      ST_PUT: begin
        if (can_push) begin
          case (op)
            MODE_BL_ON:  latch_next = latch_state | BIT_BL;
            MODE_BL_OFF: latch_next = latch_state & ~BIT_BL;
            default:     latch_next = BIT_BL;
          endcase
          push                = 1'b1;
          push_res.latch_byte = latch_next;
          push_res.strobe_res = 1'b0;
          push_res.last       = (op != MODE_INIT);
          if (op == MODE_INIT) begin
            job_next      = JOB_INIT;
            init_idx_next = '0;
            cur_byte_next = init_byte(3'd0);
            cur_rs_next   = 1'b0;
            state_next    = ST_HI;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_HI: begin
        if (can_push) begin
          latch_next          = nib_byte(cur_byte[7:4], latch_state, cur_rs);
          push                = 1'b1;
          push_res.latch_byte = latch_next;
          push_res.strobe_res = 1'b1;
          state_next          = ST_LO;
        end
      end
      ST_LO: begin
        if (can_push) begin
          latch_next          = nib_byte(cur_byte[3:0], latch_state, cur_rs);
          push                = 1'b1;
          push_res.latch_byte = latch_next;
          push_res.strobe_res = 1'b1;
          case (job)
            JOB_ROW: begin
              push_res.last = (idx == CNT_W'(COLUMNS));
              if (idx == CNT_W'(COLUMNS)) begin
                row_valid_next[r_sel] = 1'b1;
                state_next            = ST_IDLE;
              end else begin
                state_next = ST_FETCH;
              end
            end
            JOB_INIT: begin
              push_res.last = (init_idx == 3'(INIT_LEN - 1));
              if (init_idx == 3'(INIT_LEN - 1)) begin
                state_next = ST_IDLE;
              end else begin
                init_idx_next = init_idx + 3'd1;
                cur_byte_next = init_byte(init_idx + 3'd1);
                state_next    = ST_HI;
              end
            end
            default: begin
              push_res.last = 1'b1;
              state_next    = ST_IDLE;
            end
          endcase
        end
      end
      ST_FETCH: begin
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        cur_byte_next = padded;
        cur_rs_next   = 1'b1;
        shown_we      = 1'b1;
        idx_next      = idx + CNT_W'(1);
        state_next    = ST_HI;
      end
      ST_CMP_RD: begin
        state_next = ST_CMP_CHK;
      end
      ST_CMP_CHK: begin
        if (padded != shown_q) begin
          cur_byte_next = cursor_base(r_sel);
          cur_rs_next   = 1'b0;
          job_next      = JOB_ROW;
          idx_next      = '0;
          state_next    = ST_HI;
        end else if (idx == CNT_W'(COLUMNS - 1)) begin
          state_next = ST_IDLE;
        end else begin
          idx_next   = idx + CNT_W'(1);
          state_next = ST_CMP_RD;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  lcdrc_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_res (push_res),
    .can_push (can_push),
    .result   (result)
  );
endmodule
